// ----- src/sva_pkg.sv -----
// ============================================================================
// sva_pkg
// shared types and constants of the voice allocator: sizes, event and command
// codes, and the control/status bundles between controller and datapath
// ============================================================================
package sva_pkg;

    // voice pool and derived widths
    localparam int NUM_VOICES  = 8;
    localparam int IDX_W       = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // note space
    localparam int NOTE_W    = 7;
    localparam int NUM_NOTES = 128;

    // note and pedal thresholds
    localparam logic [NOTE_W-1:0] GLIDE_TOP_NOTE  = 7'd57;
    localparam logic [NOTE_W-1:0] PEDAL_THRESHOLD = 7'd64;

    // exciter codes
    localparam logic [2:0] EXC_NOISE = 3'd2;
    localparam logic [2:0] EXC_BOW   = 3'd3;
    localparam logic [2:0] EXC_WIND  = 3'd4;

    // input event codes
    typedef enum logic [2:0] {
        ACT_NOTE_ON      = 3'd0,
        ACT_NOTE_OFF     = 3'd1,
        ACT_PEDAL        = 3'd2,
        ACT_ALL_OFF      = 3'd3,
        ACT_VOICE_SILENT = 3'd4
    } t_action;

    // result command codes
    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_RELEASE  = 2'd1,
        CMD_STOP_ALL = 2'd2
    } t_command;

    // controller to datapath
    typedef struct packed {
        logic latch;       // capture the accepted event
        logic exec;        // carry out a single-step event
        logic start_scan;  // pedal up: lift pedal, rewind the held-note walk
        logic scan_step;   // examine one held note
        logic flush;       // send the last held result
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        t_action action;
        logic    pedal_down;
        logic    pedal_req_down;
        logic    scan_last;
    } t_dp_status;

endpackage

// ----- src/synth_voice_allocator_core.sv -----
// ============================================================================
// synth_voice_allocator_core
// polyphonic voice allocator with oldest-voice stealing, low-note glide and
// sustain pedal hold; top level with the register port
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  event     in         start & !busy               i_action i_note i_velocity
//                                                   i_pedal_value i_voice_index
//  result    out        o_result_valid (1 cycle)    o_command o_voice o_note_out
//                                                   o_velocity_out o_stolen
//                                                   o_sustaining o_last
//  register  in/out     psel penable pwrite pready  paddr pwdata prdata
//
//  an event is taken only while busy is low, so not before the last one is
//  done; its result is registered in the decode state after the capture
//  pedal up walks all 128 notes of the held mask one per cycle in the datapath
//  and stays busy to its end; results come out during the walk and at its end
//  synchronous active-low reset idles all voices, lifts the pedal and clears
//  the held-note mask at once; the receiver cannot stall results
// ============================================================================
module synth_voice_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [6:0]  i_note,
    input  logic [6:0]  i_velocity,
    input  logic [6:0]  i_pedal_value,
    input  logic [2:0]  i_voice_index,
    // result channel
    output logic        o_result_valid,
    output logic [1:0]  o_command,
    output logic [2:0]  o_voice,
    output logic [6:0]  o_note_out,
    output logic [6:0]  o_velocity_out,
    output logic        o_stolen,
    output logic        o_sustaining,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // register index, taken from the word address bit
    localparam logic REG_EXCITER_TYPE = 1'b0;

    logic                r_exciter_type_v;
    logic [2:0]          r_exciter_type, n_exciter_type;
    logic                w_cfg_write;
    sva_pkg::t_ctrl_cmd  w_cmd;
    sva_pkg::t_dp_status w_status;

    // register write on the access cycle of a write transfer
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_exciter_type = r_exciter_type;
        if (w_cfg_write && (paddr[2] == REG_EXCITER_TYPE)) n_exciter_type = pwdata[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exciter_type   <= '0;
            r_exciter_type_v <= 1'b0;
        end else begin
            r_exciter_type   <= n_exciter_type;
            r_exciter_type_v <= r_exciter_type_v | w_cfg_write;
        end
    end

    // register read
    assign prdata = (paddr[2] == REG_EXCITER_TYPE) ? {29'd0, r_exciter_type} : 32'd0;

    sva_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    sva_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_exciter_type (r_exciter_type),
        .i_action       (i_action),
        .i_note         (i_note),
        .i_velocity     (i_velocity),
        .i_pedal_value  (i_pedal_value),
        .i_voice_index  (i_voice_index),
        .o_result_valid (o_result_valid),
        .o_command      (o_command),
        .o_voice        (o_voice),
        .o_note_out     (o_note_out),
        .o_velocity_out (o_velocity_out),
        .o_stolen       (o_stolen),
        .o_sustaining   (o_sustaining),
        .o_last         (o_last)
    );

    // the exciter register reads back zero until first written
    a_cfg_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_exciter_type_v |-> (r_exciter_type == '0))
        else $error("exciter register changed without a write");

    // busy rises right after every event transfer
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after event transfer");

    // only a pedal-up walk gives non-final results, and it keeps busy high
    a_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |-> busy)
        else $error("non-final result outside a pedal-up walk");

endmodule

// ----- src/sva_ctrl.sv -----
// ============================================================================
// sva_ctrl
// controller state machine: decodes the captured event, runs the held-note
// walk at pedal up and the final flush, and raises busy
// ============================================================================
module sva_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  sva_pkg::t_dp_status   i_status,
    output sva_pkg::t_ctrl_cmd    o_cmd,
    output logic                  o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy,  n_busy;
    logic   w_pedal_up;

    // a pedal-up event that finds the pedal down starts the walk
    assign w_pedal_up = (i_status.action == sva_pkg::ACT_PEDAL) &&
                        !i_status.pedal_req_down && i_status.pedal_down;

    // command decode
    always_comb begin
        o_cmd            = '0;
        o_cmd.latch      = (r_state == ST_IDLE) && i_start;
        o_cmd.start_scan = (r_state == ST_DECODE) && w_pedal_up;
        o_cmd.exec       = (r_state == ST_DECODE) && !w_pedal_up;
        o_cmd.scan_step  = (r_state == ST_SCAN);
        o_cmd.flush      = (r_state == ST_FLUSH);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                n_state = w_pedal_up ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (i_status.scan_last) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        n_busy = (n_state != ST_IDLE);
    end

    // state and busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- src/sva_datapath.sv -----
// ============================================================================
// sva_datapath
// voice table, age ranks, pedal and held-note mask, voice searches and the
// result register with a one-deep holding stage for the pedal-up walk
// ============================================================================
module sva_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sva_pkg::t_ctrl_cmd   i_cmd,
    output sva_pkg::t_dp_status  o_status,
    input  logic [2:0]           i_exciter_type,
    input  logic [2:0]           i_action,
    input  logic [6:0]           i_note,
    input  logic [6:0]           i_velocity,
    input  logic [6:0]           i_pedal_value,
    input  logic [2:0]           i_voice_index,
    output logic                 o_result_valid,
    output logic [1:0]           o_command,
    output logic [2:0]           o_voice,
    output logic [6:0]           o_note_out,
    output logic [6:0]           o_velocity_out,
    output logic                 o_stolen,
    output logic                 o_sustaining,
    output logic                 o_last
);

    localparam int NV  = sva_pkg::NUM_VOICES;
    localparam int IW  = sva_pkg::IDX_W;
    localparam int NW  = sva_pkg::NOTE_W;
    localparam int CW  = sva_pkg::CNT_W;
    localparam int NN  = sva_pkg::NUM_NOTES;

    // captured event
    sva_pkg::t_action r_action, n_action;
    logic [NW-1:0]    r_note, n_note;
    logic [NW-1:0]    r_velocity, n_velocity;
    logic             r_pedal_req, n_pedal_req;
    logic [2:0]       r_voice_index, n_voice_index;

    // voice table and pedal state
    logic [NV-1:0]    r_active, n_active;
    logic [NW-1:0]    r_vnote [NV];
    logic [NW-1:0]    n_vnote [NV];
    logic [IW-1:0]    r_rank  [NV];
    logic [IW-1:0]    n_rank  [NV];
    logic [NV-1:0]    r_sus, n_sus;
    logic             r_pedal, n_pedal;
    logic [NN-1:0]    r_mask, n_mask;

    // held-note walk
    logic [NW-1:0]    r_scan_cnt, n_scan_cnt;
    logic [CW-1:0]    r_res_cnt, n_res_cnt;
    logic             r_pend_valid, n_pend_valid;
    logic [IW-1:0]    r_pend_voice, n_pend_voice;
    logic [NW-1:0]    r_pend_note, n_pend_note;

    // result register
    logic             r_out_valid, n_out_valid;
    sva_pkg::t_command r_out_cmd, n_out_cmd;
    logic [2:0]       r_out_voice, n_out_voice;
    logic [NW-1:0]    r_out_note, n_out_note;
    logic [NW-1:0]    r_out_vel, n_out_vel;
    logic             r_out_stolen, n_out_stolen;
    logic             r_out_sus, n_out_sus;
    logic             r_out_last, n_out_last;

    // search results
    logic [NW-1:0]    w_search_note;
    logic             w_rel_found;
    logic [IW-1:0]    w_rel_voice;
    logic             w_new_found;
    logic [IW-1:0]    w_new_voice;
    logic             w_free_found;
    logic [IW-1:0]    w_free_voice;
    logic [IW-1:0]    w_old_voice;
    logic             w_glide;
    logic             w_sus_start;
    logic [IW-1:0]    w_start_voice;
    logic [IW-1:0]    w_silent_idx;
    logic [NV-1:0]    w_rank_seen;

    // newest active voice playing the searched note
    assign w_search_note = i_cmd.scan_step ? r_scan_cnt : r_note;

    always_comb begin
        w_rel_found = 1'b0;
        w_rel_voice = '0;
        for (int i = 0; i < NV; i++) begin
            if (r_active[i] && (r_vnote[i] == w_search_note) &&
                (!w_rel_found || (r_rank[i] > r_rank[w_rel_voice]))) begin
                w_rel_found = 1'b1;
                w_rel_voice = IW'(i);
            end
        end
    end

    // newest active voice, first free voice, oldest voice
    always_comb begin
        w_new_found  = 1'b0;
        w_new_voice  = '0;
        w_free_found = 1'b0;
        w_free_voice = '0;
        w_old_voice  = '0;
        for (int i = 0; i < NV; i++) begin
            if (r_active[i] && (!w_new_found || (r_rank[i] > r_rank[w_new_voice]))) begin
                w_new_found = 1'b1;
                w_new_voice = IW'(i);
            end
        end
        for (int i = NV - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_found = 1'b1;
                w_free_voice = IW'(i);
            end
            if (r_rank[i] == '0) w_old_voice = IW'(i);
        end
    end

    // note-on voice choice
    assign w_glide       = (r_note <= sva_pkg::GLIDE_TOP_NOTE) &&
                           (i_exciter_type <= sva_pkg::EXC_NOISE);
    assign w_sus_start   = (i_exciter_type == sva_pkg::EXC_BOW) ||
                           (i_exciter_type == sva_pkg::EXC_WIND);
    assign w_start_voice = (w_glide && w_new_found) ? w_new_voice :
                           (w_free_found ? w_free_voice : w_old_voice);
    assign w_silent_idx  = IW'(r_voice_index);

    // next-state logic of the whole datapath
    always_comb begin
        n_action      = r_action;
        n_note        = r_note;
        n_velocity    = r_velocity;
        n_pedal_req   = r_pedal_req;
        n_voice_index = r_voice_index;
        n_active      = r_active;
        n_vnote       = r_vnote;
        n_rank        = r_rank;
        n_sus         = r_sus;
        n_pedal       = r_pedal;
        n_mask        = r_mask;
        n_scan_cnt    = r_scan_cnt;
        n_res_cnt     = r_res_cnt;
        n_pend_valid  = r_pend_valid;
        n_pend_voice  = r_pend_voice;
        n_pend_note   = r_pend_note;
        n_out_valid   = 1'b0;
        n_out_cmd     = r_out_cmd;
        n_out_voice   = r_out_voice;
        n_out_note    = r_out_note;
        n_out_vel     = r_out_vel;
        n_out_stolen  = r_out_stolen;
        n_out_sus     = r_out_sus;
        n_out_last    = r_out_last;

        // capture the event on transfer
        if (i_cmd.latch) begin
            n_action      = sva_pkg::t_action'(i_action);
            n_note        = i_note;
            n_velocity    = i_velocity;
            n_pedal_req   = (i_pedal_value >= sva_pkg::PEDAL_THRESHOLD);
            n_voice_index = i_voice_index;
        end

        // single-step events
        if (i_cmd.exec) begin
            case (r_action)
                sva_pkg::ACT_NOTE_ON: begin
                    n_active[w_start_voice] = 1'b1;
                    n_vnote[w_start_voice]  = r_note;
                    n_sus[w_start_voice]    = w_sus_start;
                    for (int i = 0; i < NV; i++) begin
                        if (r_rank[i] > r_rank[w_start_voice]) n_rank[i] = r_rank[i] - 1'b1;
                    end
                    n_rank[w_start_voice] = IW'(NV - 1);
                    n_out_valid  = 1'b1;
                    n_out_cmd    = sva_pkg::CMD_START;
                    n_out_voice  = 3'(w_start_voice);
                    n_out_note   = r_note;
                    n_out_vel    = r_velocity;
                    n_out_stolen = r_active[w_start_voice];
                    n_out_sus    = w_sus_start;
                    n_out_last   = 1'b1;
                end
                sva_pkg::ACT_NOTE_OFF: begin
                    if (r_pedal) begin
                        n_mask[r_note] = 1'b1;
                    end else if (w_rel_found) begin
                        n_sus[w_rel_voice] = 1'b0;
                        n_out_valid  = 1'b1;
                        n_out_cmd    = sva_pkg::CMD_RELEASE;
                        n_out_voice  = 3'(w_rel_voice);
                        n_out_note   = r_note;
                        n_out_vel    = '0;
                        n_out_stolen = 1'b0;
                        n_out_sus    = 1'b0;
                        n_out_last   = 1'b1;
                    end
                end
                sva_pkg::ACT_PEDAL: begin
                    if (r_pedal_req && !r_pedal) n_pedal = 1'b1;
                end
                sva_pkg::ACT_ALL_OFF: begin
                    n_mask       = '0;
                    n_pedal      = 1'b0;
                    n_active     = '0;
                    n_sus        = '0;
                    n_out_valid  = 1'b1;
                    n_out_cmd    = sva_pkg::CMD_STOP_ALL;
                    n_out_voice  = '0;
                    n_out_note   = '0;
                    n_out_vel    = '0;
                    n_out_stolen = 1'b0;
                    n_out_sus    = 1'b0;
                    n_out_last   = 1'b1;
                end
                sva_pkg::ACT_VOICE_SILENT: begin
                    if ((32'(r_voice_index) < NV) && !r_sus[w_silent_idx]) begin
                        n_active[w_silent_idx] = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        // pedal up: rewind the walk
        if (i_cmd.start_scan) begin
            n_pedal      = 1'b0;
            n_scan_cnt   = '0;
            n_res_cnt    = '0;
            n_pend_valid = 1'b0;
        end

        // one held note per cycle; a found release waits in the holding
        // stage until the next one shows whether it is the last
        if (i_cmd.scan_step) begin
            n_scan_cnt = r_scan_cnt + 1'b1;
            if (r_mask[r_scan_cnt]) begin
                n_mask[r_scan_cnt] = 1'b0;
                if (w_rel_found) begin
                    n_sus[w_rel_voice] = 1'b0;
                    if (r_res_cnt < CW'(sva_pkg::MAX_RESULTS)) begin
                        n_res_cnt    = r_res_cnt + 1'b1;
                        n_pend_valid = 1'b1;
                        n_pend_voice = w_rel_voice;
                        n_pend_note  = r_scan_cnt;
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_cmd    = sva_pkg::CMD_RELEASE;
                            n_out_voice  = 3'(r_pend_voice);
                            n_out_note   = r_pend_note;
                            n_out_vel    = '0;
                            n_out_stolen = 1'b0;
                            n_out_sus    = 1'b0;
                            n_out_last   = 1'b0;
                        end
                    end
                end
            end
        end

        // end of walk: the held result is the last one
        if (i_cmd.flush && r_pend_valid) begin
            n_pend_valid = 1'b0;
            n_out_valid  = 1'b1;
            n_out_cmd    = sva_pkg::CMD_RELEASE;
            n_out_voice  = 3'(r_pend_voice);
            n_out_note   = r_pend_note;
            n_out_vel    = '0;
            n_out_stolen = 1'b0;
            n_out_sus    = 1'b0;
            n_out_last   = 1'b1;
        end
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_sus        <= '0;
            r_pedal      <= 1'b0;
            r_mask       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_res_cnt    <= '0;
            for (int i = 0; i < NV; i++) r_rank[i] <= IW'(i);
        end else begin
            r_active     <= n_active;
            r_sus        <= n_sus;
            r_pedal      <= n_pedal;
            r_mask       <= n_mask;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_res_cnt    <= n_res_cnt;
            r_rank       <= n_rank;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_action      <= n_action;
        r_note        <= n_note;
        r_velocity    <= n_velocity;
        r_pedal_req   <= n_pedal_req;
        r_voice_index <= n_voice_index;
        r_vnote       <= n_vnote;
        r_scan_cnt    <= n_scan_cnt;
        r_pend_voice  <= n_pend_voice;
        r_pend_note   <= n_pend_note;
        r_out_cmd     <= n_out_cmd;
        r_out_voice   <= n_out_voice;
        r_out_note    <= n_out_note;
        r_out_vel     <= n_out_vel;
        r_out_stolen  <= n_out_stolen;
        r_out_sus     <= n_out_sus;
        r_out_last    <= n_out_last;
    end

    // status to the controller
    assign o_status.action         = r_action;
    assign o_status.pedal_down     = r_pedal;
    assign o_status.pedal_req_down = r_pedal_req;
    assign o_status.scan_last      = (r_scan_cnt == NW'(NN - 1));

    // result ports
    assign o_result_valid = r_out_valid;
    assign o_command      = r_out_cmd;
    assign o_voice        = r_out_voice;
    assign o_note_out     = r_out_note;
    assign o_velocity_out = r_out_vel;
    assign o_stolen       = r_out_stolen;
    assign o_sustaining   = r_out_sus;
    assign o_last         = r_out_last;

    // which ranks are in use
    always_comb begin
        w_rank_seen = '0;
        for (int i = 0; i < NV; i++) w_rank_seen[r_rank[i]] = 1'b1;
    end

    // age ranks always form a permutation of the voices
    a_rank_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_rank_seen))
        else $error("age ranks are not a permutation");

    // the walk never reports more than the result limit
    a_res_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_cnt <= CW'(sva_pkg::MAX_RESULTS)))
        else $error("pedal-up result count over limit");

    // stop-all leaves every voice idle and the pedal up
    a_stop_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_cmd == sva_pkg::CMD_STOP_ALL)) |->
        ((r_active == '0) && !r_pedal && (r_mask == '0)))
        else $error("voices left active after stop-all");

    // the held-note mask is empty once the walk has ended
    a_mask_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_mask == '0) && !r_pend_valid)
        else $error("held notes remain after pedal up");

endmodule

// ----- dv/synth_voice_allocator_core_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// synth_voice_allocator_core_checker
// watches the event, result and register channels of the voice allocator,
// keeps its own voice table to work out the voice commands each event should
// cause, and compares every result transfer with the oldest expected command
// ============================================================================
module synth_voice_allocator_core_checker
    import sva_pkg::*;
#(
    parameter logic [2:0] EXCITER_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_action,
    input  logic [6:0]  i_note,
    input  logic [6:0]  i_velocity,
    input  logic [6:0]  i_pedal_value,
    input  logic [2:0]  i_voice_index,
    // result channel
    input  logic        i_result_valid,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_voice,
    input  logic [6:0]  i_note_out,
    input  logic [6:0]  i_velocity_out,
    input  logic        i_stolen,
    input  logic        i_sustaining,
    input  logic        i_last,
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    // status to the testbench top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_command         command;
        logic [IDX_W-1:0] voice;
        logic [6:0]       note;
        logic [6:0]       velocity;
        logic             stolen;
        logic             sustaining;
        logic             last;
    } t_voice_cmd;

    // expected voice commands, oldest first
    t_voice_cmd           expected_cmds[$];

    // predicted allocator state
    logic [2:0]           exciter;
    logic                 active     [NUM_VOICES];
    logic [6:0]           voice_note [NUM_VOICES];
    logic [IDX_W-1:0]     age_rank   [NUM_VOICES];
    logic                 sustain    [NUM_VOICES];
    logic                 pedal;
    logic [NUM_NOTES-1:0] held;

    function automatic string describe(t_voice_cmd c);
        return $sformatf("cmd=%0d voice=%0d note=%0d vel=%0d stolen=%0b sus=%0b last=%0b",
                         c.command, c.voice, c.note, c.velocity, c.stolen,
                         c.sustaining, c.last);
    endfunction

    function automatic void report_failure(string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    function automatic void reset_model();
        exciter = '0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            active[i]     = 1'b0;
            voice_note[i] = '0;
            age_rank[i]   = IDX_W'(i);
            sustain[i]    = 1'b0;
        end
        pedal = 1'b0;
        held  = '0;
        expected_cmds.delete();
        o_fail_count = 0;
        o_checked    = 0;
    endfunction

    // newest active voice, -1 when none is active
    function automatic int newest_voice();
        int best;
        best = -1;
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (active[i] && (best < 0 || age_rank[i] > age_rank[best])) best = i;
        end
        return best;
    endfunction

    // first idle voice, else the oldest one
    function automatic int voice_for_start();
        int best;
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (!active[i]) return i;
        end
        best = 0;
        for (int i = 1; i < NUM_VOICES; i++) begin
            if (age_rank[i] < age_rank[best]) best = i;
        end
        return best;
    endfunction

    // started voice becomes newest, ranks above it slide down
    function automatic void promote(int v);
        logic [IDX_W-1:0] old_rank;
        old_rank = age_rank[v];
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (age_rank[i] > old_rank) age_rank[i] = age_rank[i] - 1'b1;
        end
        age_rank[v] = IDX_W'(NUM_VOICES - 1);
    endfunction

    // release the newest active voice on note n, -1 when none plays it
    function automatic int release_voice(logic [6:0] n);
        int best;
        best = -1;
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (active[i] && voice_note[i] == n &&
                (best < 0 || age_rank[i] > age_rank[best])) best = i;
        end
        if (best >= 0) sustain[best] = 1'b0;
        return best;
    endfunction

    // work out the commands one accepted event causes
    function automatic void predict_event(logic [2:0] act, logic [6:0] note,
                                          logic [6:0] vel, logic [6:0] pv,
                                          logic [2:0] vi);
        t_voice_cmd batch[$];
        t_voice_cmd c;
        logic       glide;
        logic       sus;
        int         v;
        case (act)
            ACT_NOTE_ON: begin
                glide = (note <= GLIDE_TOP_NOTE) && (exciter <= EXC_NOISE);
                sus   = (exciter == EXC_BOW) || (exciter == EXC_WIND);
                v     = glide ? newest_voice() : -1;
                if (v < 0) v = voice_for_start();
                c = '{CMD_START, IDX_W'(v), note, vel, active[v], sus, 1'b0};
                active[v]     = 1'b1;
                voice_note[v] = note;
                sustain[v]    = sus;
                promote(v);
                batch = {batch, c};
            end
            ACT_NOTE_OFF: begin
                if (pedal) begin
                    held[note] = 1'b1;
                end else begin
                    v = release_voice(note);
                    if (v >= 0) begin
                        c = '{CMD_RELEASE, IDX_W'(v), note, 7'd0, 1'b0, 1'b0, 1'b0};
                        batch = {batch, c};
                    end
                end
            end
            ACT_PEDAL: begin
                if (pv >= PEDAL_THRESHOLD && !pedal) begin
                    pedal = 1'b1;
                end else if (pv < PEDAL_THRESHOLD && pedal) begin
                    // pedal up: held notes go out in ascending order
                    pedal = 1'b0;
                    for (int n = 0; n < NUM_NOTES; n++) begin
                        if (held[n]) begin
                            held[n] = 1'b0;
                            v = release_voice(7'(n));
                            if (v >= 0 && batch.size() < MAX_RESULTS) begin
                                c = '{CMD_RELEASE, IDX_W'(v), 7'(n), 7'd0,
                                      1'b0, 1'b0, 1'b0};
                                batch = {batch, c};
                            end
                        end
                    end
                end
            end
            ACT_ALL_OFF: begin
                held  = '0;
                pedal = 1'b0;
                for (int i = 0; i < NUM_VOICES; i++) begin
                    active[i]  = 1'b0;
                    sustain[i] = 1'b0;
                end
                c = '{CMD_STOP_ALL, '0, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0};
                batch = {batch, c};
            end
            ACT_VOICE_SILENT: begin
                // bowed or blown voices keep sounding until released
                if (vi < NUM_VOICES && !sustain[vi]) active[vi] = 1'b0;
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        expected_cmds = {expected_cmds, batch};
    endfunction

    // compare one result transfer with the oldest expectation
    function automatic void check_result();
        t_voice_cmd got;
        t_voice_cmd want;
        got = '{t_command'(i_command), i_voice, i_note_out, i_velocity_out,
                i_stolen, i_sustaining, i_last};
        if (expected_cmds.size() == 0) begin
            report_failure({"unexpected voice command: ", describe(got)});
        end else begin
            want = expected_cmds.pop_front();
            o_checked++;
            if (got.command !== want.command || got.voice !== want.voice ||
                got.note !== want.note || got.velocity !== want.velocity ||
                got.stolen !== want.stolen || got.sustaining !== want.sustaining ||
                got.last !== want.last) begin
                report_failure({"voice command mismatch: expected ", describe(want),
                                " got ", describe(got)});
            end
        end
    endfunction

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_result_valid) check_result();
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == EXCITER_ADDR) begin
                exciter = i_pwdata[2:0];
            end
            if (i_start && !i_busy) begin
                predict_event(i_action, i_note, i_velocity, i_pedal_value, i_voice_index);
            end
        end
        o_pending = expected_cmds.size();
    end

endmodule

// ----- dv/synth_voice_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// synth_voice_allocator_core_tb
// drives note, pedal, all-off, voice-silent and undefined events into the voice
// allocator: a directed run over the corner cases, then random phases under
// one exciter setting each, mostly with random gaps; the checker judges the results
// ============================================================================
module synth_voice_allocator_core_tb;
    import sva_pkg::*;

    localparam logic [2:0] REG_EXCITER_ADDR = 3'd0;
    localparam logic [2:0] EXC_STRIKE       = 3'd0;
    localparam logic [2:0] EXC_PLUCK        = 3'd1;
    localparam logic [2:0] EXC_UNDEF_FIRST  = 3'd5;
    localparam logic [2:0] EXC_UNDEF_LAST   = 3'd7;
    localparam logic [2:0] ACT_UNDEF_FIRST  = 3'd5;
    localparam logic [2:0] ACT_UNDEF_LAST   = 3'd7;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 22;
    localparam int DRAIN_CYCLES    = 140;
    localparam int IDLE_LIMIT      = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_action;
    logic [6:0]  i_note;
    logic [6:0]  i_velocity;
    logic [6:0]  i_pedal_value;
    logic [2:0]  i_voice_index;
    logic        o_result_valid;
    logic [1:0]  o_command;
    logic [2:0]  o_voice;
    logic [6:0]  o_note_out;
    logic [6:0]  o_velocity_out;
    logic        o_stolen;
    logic        o_sustaining;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          checked;
    int          idle_cycles;
    int          action_count [8];
    logic        no_gaps;
    logic        pedal_held;
    logic [2:0]  phase_exciter [NUM_PHASES];

    synth_voice_allocator_core u_top (.*);

    synth_voice_allocator_core_checker #(
        .EXCITER_ADDR (REG_EXCITER_ADDR)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_note         (i_note),
        .i_velocity     (i_velocity),
        .i_pedal_value  (i_pedal_value),
        .i_voice_index  (i_voice_index),
        .i_result_valid (o_result_valid),
        .i_command      (o_command),
        .i_voice        (o_voice),
        .i_note_out     (o_note_out),
        .i_velocity_out (o_velocity_out),
        .i_stolen       (o_stolen),
        .i_sustaining   (o_sustaining),
        .i_last         (o_last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // 100 MHz clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((start && !busy) || o_result_valid ||
                     (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // one event transfer, entered and left at a falling edge
    task automatic send_event(input logic [2:0] act, input logic [6:0] note,
                              input logic [6:0] vel, input logic [6:0] pv,
                              input logic [2:0] vi);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_note        <= note;
        i_velocity    <= vel;
        i_pedal_value <= pv;
        i_voice_index <= vi;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        action_count[act]++;
        if (act == ACT_PEDAL) pedal_held = (pv >= PEDAL_THRESHOLD);
        if (act == ACT_ALL_OFF) pedal_held = 1'b0;
    endtask

    // hold events back until every expected command is out and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // register write: setup then access cycle
    task automatic write_exciter(input logic [2:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_EXCITER_ADDR;
        pwdata  <= {29'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int         counted;
        int         pick;
        logic [2:0] act;
        logic [6:0] note;
        logic [6:0] pv;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_action      = '0;
        i_note        = '0;
        i_velocity    = '0;
        i_pedal_value = '0;
        i_voice_index = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        no_gaps       = 1'b0;
        pedal_held    = 1'b0;
        foreach (action_count[i]) action_count[i] = 0;
        phase_exciter = '{EXC_PLUCK, EXC_WIND, EXC_UNDEF_LAST, EXC_NOISE, EXC_BOW,
                          EXC_STRIKE, EXC_UNDEF_FIRST, 3'($urandom_range(0, 7))};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: struck exciter from reset, glide on low notes
        send_event(ACT_NOTE_ON, 7'd60, 7'd127, 7'd0, 3'd0);
        send_event(ACT_NOTE_ON, 7'd0, 7'd0, 7'd0, 3'd0);
        send_event(ACT_NOTE_ON, 7'd127, 7'd1, 7'd0, 3'd0);
        send_event(ACT_NOTE_ON, GLIDE_TOP_NOTE, 7'd64, 7'd0, 3'd0);
        send_event(ACT_NOTE_ON, GLIDE_TOP_NOTE + 7'd1, 7'd5, 7'd0, 3'd0);
        send_event(ACT_NOTE_OFF, GLIDE_TOP_NOTE, 7'd0, 7'd0, 3'd0);
        // release of a note nobody plays
        send_event(ACT_NOTE_OFF, 7'd5, 7'd0, 7'd0, 3'd0);
        send_event(ACT_VOICE_SILENT, 7'd0, 7'd0, 7'd0, 3'd1);
        send_event(ACT_VOICE_SILENT, 7'd0, 7'd0, 7'd0, 3'd7);
        // pedal hold: repeated down, duplicate and orphan releases
        send_event(ACT_PEDAL, 7'd0, 7'd0, PEDAL_THRESHOLD, 3'd0);
        send_event(ACT_PEDAL, 7'd0, 7'd0, 7'd127, 3'd0);
        send_event(ACT_NOTE_OFF, 7'd0, 7'd0, 7'd0, 3'd0);
        send_event(ACT_NOTE_OFF, 7'd0, 7'd0, 7'd0, 3'd0);
        send_event(ACT_NOTE_OFF, 7'd99, 7'd0, 7'd0, 3'd0);
        send_event(ACT_NOTE_OFF, GLIDE_TOP_NOTE + 7'd1, 7'd0, 7'd0, 3'd0);
        send_event(ACT_PEDAL, 7'd0, 7'd0, PEDAL_THRESHOLD - 7'd1, 3'd0);
        send_event(ACT_PEDAL, 7'd0, 7'd0, 7'd0, 3'd0);
        send_event(ACT_UNDEF_FIRST, 7'd60, 7'd60, 7'd0, 3'd0);
        send_event(ACT_UNDEF_LAST, 7'd60, 7'd60, 7'd0, 3'd0);
        // fill the pool, then steal the oldest voice
        for (int n = 70; n < 77; n++) send_event(ACT_NOTE_ON, 7'(n), 7'(n), 7'd0, 3'd0);
        send_event(ACT_ALL_OFF, 7'd0, 7'd0, 7'd0, 3'd0);

        // bowed voice ignores silence until released
        drain();
        write_exciter(EXC_BOW);
        send_event(ACT_NOTE_ON, 7'd40, 7'd100, 7'd0, 3'd0);
        send_event(ACT_VOICE_SILENT, 7'd0, 7'd0, 7'd0, 3'd0);
        send_event(ACT_NOTE_OFF, 7'd40, 7'd0, 7'd0, 3'd0);
        send_event(ACT_VOICE_SILENT, 7'd0, 7'd0, 7'd0, 3'd0);

        // random phases, one exciter setting each
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            write_exciter(phase_exciter[phase]);
            no_gaps = ($urandom_range(0, 3) == 0);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 34)      act = ACT_NOTE_ON;
                else if (pick < 62) act = ACT_NOTE_OFF;
                else if (pick < 76) act = ACT_PEDAL;
                else if (pick < 80) act = ACT_ALL_OFF;
                else if (pick < 95) act = ACT_VOICE_SILENT;
                else                act = 3'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
                // mostly a narrow band around the glide limit so offs find voices
                if ($urandom_range(0, 3) == 0) note = 7'($urandom_range(0, 127));
                else note = 7'($urandom_range(GLIDE_TOP_NOTE - 6, GLIDE_TOP_NOTE + 6));
                // mostly toggle the pedal, sometimes repeat its state
                if ($urandom_range(0, 1) == 0) begin
                    pv = 7'($urandom_range(0, 127));
                end else if (pedal_held) begin
                    pv = 7'($urandom_range(0, PEDAL_THRESHOLD - 1));
                end else begin
                    pv = 7'($urandom_range(PEDAL_THRESHOLD, 127));
                end
                send_event(act, note, 7'($urandom_range(0, 127)), pv,
                           3'($urandom_range(0, 7)));
                if (act < ACT_UNDEF_FIRST) counted++;
            end
        end

        // wait for the last commands and any trailing pedal walk
        drain();
        if (pending != 0) $display("%0d expected voice commands never arrived", pending);
        $display("covered %0d note on, %0d note off, %0d pedal, %0d all off, %0d silent, %0d undefined",
                 action_count[ACT_NOTE_ON], action_count[ACT_NOTE_OFF], action_count[ACT_PEDAL],
                 action_count[ACT_ALL_OFF], action_count[ACT_VOICE_SILENT],
                 action_count[5] + action_count[6] + action_count[7]);
        $display("%0d voice commands checked over %0d exciter settings, %0d failures",
                 checked, NUM_PHASES + 2, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
